// ===== rtl/guest_region_map_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Guest region map unit: assertion macros
// Shared assertion macros. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef GUEST_REGION_MAP_UNIT_DEFINES_SVH
`define GUEST_REGION_MAP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define GRMU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: property failed");
`define GRMU_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define GRMU_ASSERT(lbl, prop)
`define GRMU_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== rtl/grmu_pkg.sv =====
// ----------------------------------------------------------------------------
// Guest region map unit: package
// Types, codes and default sizes shared by the region map modules.
// ----------------------------------------------------------------------------
package grmu_pkg;

  localparam int unsigned MaxRegionsDef = 16;
  localparam int unsigned PageBitsDef   = 12;
  localparam int unsigned AddrW         = 64;
  localparam int unsigned ProtW         = 3;
  localparam int unsigned SlotW         = 4;

  typedef enum logic [2:0] {
    CMD_CHECK   = 3'd0,
    CMD_MAP     = 3'd1,
    CMD_ALLOC   = 3'd2,
    CMD_UNMAP   = 3'd3,
    CMD_PROTECT = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_UNMAPPED = 3'd1,
    ST_PERM     = 3'd2,
    ST_OVERLAP  = 3'd3,
    ST_ZERO     = 3'd4,
    ST_WRAP     = 3'd5,
    ST_FULL     = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_ALIGN,
    S_TADD,
    S_CAND,
    S_RD,
    S_EV,
    S_APPLY,
    S_FREE,
    S_DECIDE,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [AddrW-1:0] address;
    logic [AddrW-1:0] length;
    logic [AddrW-1:0] alignment;
    logic [ProtW-1:0] prot;
    logic [ProtW-1:0] access_prot;
  } in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [AddrW-1:0] result_address;
    logic [AddrW-1:0] region_offset;
    logic [SlotW-1:0] region_slot;
  } out_t;

  // One table entry: the region is [base, limit).
  typedef struct packed {
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] limit;
    logic [ProtW-1:0] prot;
  } entry_t;

endpackage

// ===== rtl/grmu_mem.sv =====
// ----------------------------------------------------------------------------
// Guest region map unit: region store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module grmu_mem import grmu_pkg::*; #(
  parameter int unsigned MAX_REGIONS = MaxRegionsDef,
  localparam int unsigned IdxW = $clog2(MAX_REGIONS)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  entry_t          wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output entry_t          rdata_o
);

  entry_t mem_q [MAX_REGIONS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/guest_region_map_unit.sv =====
// ----------------------------------------------------------------------------
// Guest region map unit
// Table of non-overlapping page-aligned regions with permissions. One
// command word in, one result word out.
// ----------------------------------------------------------------------------
// Usage: a command word is taken on the in channel when in_valid_i and
// in_ready_o are both high; in_ready_o is high only while the unit is idle.
// The result word appears on the out channel and stays until out_ready_i.
// The cfg channel loads the allocation cursor and is taken only when idle.
// Operation: a sequencer walks the region store slot by slot through a
// single read port. A check stops at the first hit; map adds a free-slot
// search over the table. Allocate needs up to 64 alignment steps, then up
// to MAX_REGIONS+1 placement passes over the table. Unmap and protect take
// one counting pass and one applying pass, with an update per region
// touched and a free-slot search per split piece.
// Reset clears all valid bits and the cursor; the store needs no clearing.
// If the receiver stalls, a finished word waits in the output register and
// the unit holds its next result until that word is taken.
// ----------------------------------------------------------------------------
`include "guest_region_map_unit_defines.svh"

module guest_region_map_unit import grmu_pkg::*; #(
  parameter int unsigned MAX_REGIONS = MaxRegionsDef,
  parameter int unsigned PAGE_BITS   = PageBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [AddrW-1:0] cfg_data_i
);

  localparam int unsigned IdxW  = $clog2(MAX_REGIONS);
  localparam int unsigned IterW = $clog2(MAX_REGIONS + 1);
  localparam int unsigned SumW  = $clog2(3 * MAX_REGIONS + 1);
  localparam logic [AddrW-1:0] PageSize = AddrW'(1) << PAGE_BITS;
  localparam logic [AddrW-1:0] PMask    = PageSize - AddrW'(1);
  localparam logic [IdxW-1:0]  LastIdx  = IdxW'(MAX_REGIONS - 1);

  state_e state_q, state_d;

  logic [2:0]             cmd_q, cmd_d;
  logic [AddrW-1:0]       addr_q, addr_d, len_q, len_d, align_q, align_d;
  logic [ProtW-1:0]       prot_q, prot_d, ap_q, ap_d;
  logic [AddrW-1:0]       lo_q, lo_d, hi_q, hi_d, szoff_q, szoff_d;
  logic [AddrW-1:0]       cur_q, cur_d, cursor_q, cursor_d;
  logic [AddrW-1:0]       best_base_q, best_base_d, best_end_q, best_end_d;
  logic [IdxW-1:0]        idx_q, idx_d, fidx_q, fidx_d, free_q, free_d;
  logic [IterW-1:0]       iter_q, iter_d;
  logic [SumW-1:0]        cnt_q, cnt_d, need_q, need_d, nhit_q, nhit_d;
  logic [MAX_REGIONS-1:0] valid_q, valid_d;
  logic                   hit_q, hit_d, phase_q, phase_d;
  logic                   b_q, b_d, af_q, af_d, pl_q, pl_d, pu_q, pu_d;
  entry_t                 ent_q, ent_d;
  status_e                res_st_q, res_st_d;
  logic [AddrW-1:0]       res_ra_q, res_ra_d;
  logic [IdxW-1:0]        res_rs_q, res_rs_d;
  logic                   found_q, found_d;
  out_t                   out_q, out_d;
  logic                   out_valid_q, out_valid_d;

  logic                   mem_we;
  logic [IdxW-1:0]        mem_waddr;
  entry_t                 mem_wdata;
  entry_t                 rd;

  grmu_mem #(
    .MAX_REGIONS(MAX_REGIONS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (idx_q),
    .rdata_o (rd)
  );

  // Shared arithmetic and compare terms.
  logic [AddrW-1:0] base_w, szoff_w, last_w, t_w, cl_w;
  logic             hit_w, b_w, af_w, scan_last, t_wrap, cl_bad, align_odd;
  logic             free_hit, free_last, full_w, len_zero, is_split, out_take;

  assign base_w    = addr_q & ~PMask;
  assign szoff_w   = (len_q - AddrW'(1)) | PMask;
  assign last_w    = base_w + szoff_w;
  assign len_zero  = (len_q == '0);
  assign hit_w     = valid_q[idx_q] && (rd.base <= hi_q) && (rd.limit > lo_q);
  assign b_w       = lo_q > rd.base;
  assign af_w      = hi_q < (rd.limit - AddrW'(1));
  assign scan_last = (idx_q == LastIdx);
  assign t_w       = cur_q + (align_q - AddrW'(1));
  assign t_wrap    = t_w < cur_q;
  assign cl_w      = lo_q + szoff_q;
  assign cl_bad    = (cl_w < lo_q) || (&cl_w);
  assign align_odd = |(align_q & (align_q - AddrW'(1)));
  assign free_hit  = !valid_q[fidx_q];
  assign free_last = (fidx_q == LastIdx);
  assign is_split  = (cmd_q == CMD_UNMAP) || (cmd_q == CMD_PROTECT);
  assign full_w    = (cmd_q == CMD_UNMAP)
                   ? ((cnt_q + need_q) > (SumW'(MAX_REGIONS) + nhit_q))
                   : ((cnt_q + need_q) > SumW'(MAX_REGIONS));
  assign out_take  = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_PREP;
      end
      S_PREP: begin
        unique case (cmd_q)
          CMD_CHECK: state_d = S_RD;
          CMD_MAP: begin
            state_d = (len_zero || last_w < base_w || (&last_w)) ? S_FIN : S_RD;
          end
          CMD_ALLOC: state_d = len_zero ? S_FIN : S_FREE;
          CMD_UNMAP, CMD_PROTECT: begin
            state_d = (len_zero || last_w < base_w) ? S_FIN : S_RD;
          end
          default: state_d = S_FIN;
        endcase
      end
      S_RD: state_d = S_EV;
      S_EV: begin
        if (hit_w && cmd_q == CMD_CHECK) begin
          state_d = S_FIN;
        end else if (hit_w && is_split && phase_q) begin
          state_d = S_APPLY;
        end else begin
          state_d = scan_last ? S_DECIDE : S_RD;
        end
      end
      S_APPLY: begin
        if (pl_q || pu_q) begin
          state_d = S_FREE;
        end else begin
          state_d = scan_last ? S_DECIDE : S_RD;
        end
      end
      S_FREE: begin
        if (free_hit || free_last) begin
          if (is_split) begin
            state_d = S_APPLY;
          end else if (free_hit && cmd_q == CMD_ALLOC) begin
            state_d = S_ALIGN;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_ALIGN: state_d = align_odd ? S_ALIGN : S_TADD;
      S_TADD:  state_d = t_wrap ? S_FIN : S_CAND;
      S_CAND:  state_d = cl_bad ? S_FIN : S_RD;
      S_DECIDE: begin
        unique case (cmd_q)
          CMD_MAP: state_d = hit_q ? S_FIN : S_FREE;
          CMD_ALLOC: begin
            state_d = (hit_q && iter_q != IterW'(MAX_REGIONS)) ? S_TADD : S_FIN;
          end
          CMD_UNMAP, CMD_PROTECT: begin
            state_d = (!phase_q && !full_w) ? S_RD : S_FIN;
          end
          default: state_d = S_FIN;
        endcase
      end
      S_FIN: begin
        if (out_take) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and store writes.
  always_comb begin
    cmd_d       = cmd_q;
    addr_d      = addr_q;
    len_d       = len_q;
    align_d     = align_q;
    prot_d      = prot_q;
    ap_d        = ap_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    szoff_d     = szoff_q;
    cur_d       = cur_q;
    cursor_d    = cursor_q;
    best_base_d = best_base_q;
    best_end_d  = best_end_q;
    idx_d       = idx_q;
    fidx_d      = fidx_q;
    free_d      = free_q;
    iter_d      = iter_q;
    cnt_d       = cnt_q;
    need_d      = need_q;
    nhit_d      = nhit_q;
    valid_d     = valid_q;
    hit_d       = hit_q;
    phase_d     = phase_q;
    b_d         = b_q;
    af_d        = af_q;
    pl_d        = pl_q;
    pu_d        = pu_q;
    ent_d       = ent_q;
    res_st_d    = res_st_q;
    res_ra_d    = res_ra_q;
    res_rs_d    = res_rs_q;
    found_d     = found_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = '0;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cfg_valid_i) cursor_d = cfg_data_i;
        if (in_valid_i) begin
          cmd_d    = in_data_i.cmd;
          addr_d   = in_data_i.address;
          len_d    = in_data_i.length;
          align_d  = in_data_i.alignment;
          prot_d   = in_data_i.prot;
          ap_d     = in_data_i.access_prot;
          hit_d    = 1'b0;
          phase_d  = 1'b0;
          cnt_d    = '0;
          need_d   = '0;
          nhit_d   = '0;
          iter_d   = '0;
          pl_d     = 1'b0;
          pu_d     = 1'b0;
          res_st_d = ST_OK;
          res_ra_d = '0;
          res_rs_d = '0;
          found_d  = 1'b0;
        end
      end
      S_PREP: begin
        // A check is a hit test against the one-byte range at the address.
        lo_d    = (cmd_q == CMD_CHECK) ? addr_q : base_w;
        hi_d    = (cmd_q == CMD_CHECK) ? addr_q : last_w;
        szoff_d = szoff_w;
        cur_d   = cursor_q;
        unique case (cmd_q)
          CMD_CHECK: res_st_d = ST_UNMAPPED;
          CMD_MAP: begin
            if (len_zero) res_st_d = ST_ZERO;
            else if (last_w < base_w || (&last_w)) res_st_d = ST_WRAP;
          end
          CMD_ALLOC: begin
            if (len_zero) res_st_d = ST_ZERO;
          end
          CMD_UNMAP, CMD_PROTECT: begin
            if (!len_zero && last_w < base_w) res_st_d = ST_WRAP;
          end
          default: res_st_d = ST_OK;
        endcase
      end
      S_EV: begin
        if (!(hit_w && is_split && phase_q)) begin
          idx_d = (scan_last || (hit_w && cmd_q == CMD_CHECK)) ? '0 : idx_q + IdxW'(1);
        end
        case (cmd_q)
          CMD_CHECK: begin
            if (hit_w) begin
              res_st_d = ((rd.prot & ap_q) == ap_q) ? ST_OK : ST_PERM;
              res_ra_d = rd.base;
              res_rs_d = idx_q;
              found_d  = 1'b1;
            end
          end
          CMD_MAP: begin
            if (hit_w) hit_d = 1'b1;
          end
          CMD_ALLOC: begin
            // Keep the lowest-based colliding region.
            if (hit_w && (!hit_q || rd.base < best_base_q)) begin
              hit_d       = 1'b1;
              best_base_d = rd.base;
              best_end_d  = rd.limit;
            end
          end
          CMD_UNMAP, CMD_PROTECT: begin
            if (!phase_q) begin
              cnt_d = cnt_q + SumW'(valid_q[idx_q]);
              if (hit_w) begin
                need_d = need_q + SumW'(b_w) + SumW'(af_w);
                nhit_d = nhit_q + SumW'(1);
              end
            end else if (hit_w) begin
              ent_d = rd;
              b_d   = b_w;
              af_d  = af_w;
              if (cmd_q == CMD_UNMAP) begin
                pl_d = 1'b0;
                pu_d = b_w && af_w;
              end else begin
                pl_d = b_w;
                pu_d = af_w;
              end
            end
          end
          default: ;
        endcase
      end
      S_APPLY: begin
        if (!(pl_q || pu_q)) begin
          idx_d = scan_last ? '0 : idx_q + IdxW'(1);
          if (cmd_q == CMD_UNMAP) begin
            if (!b_q && !af_q) begin
              valid_d[idx_q] = 1'b0;
            end else if (b_q) begin
              mem_we    = 1'b1;
              mem_wdata = '{base: ent_q.base, limit: lo_q, prot: ent_q.prot};
            end else begin
              mem_we    = 1'b1;
              mem_wdata = '{base: hi_q + AddrW'(1), limit: ent_q.limit, prot: ent_q.prot};
            end
          end else begin
            mem_we    = 1'b1;
            mem_wdata = '{base:  b_q ? lo_q : ent_q.base,
                          limit: af_q ? hi_q + AddrW'(1) : ent_q.limit,
                          prot:  prot_q};
          end
        end
      end
      S_FREE: begin
        fidx_d = (free_hit || free_last) ? '0 : fidx_q + IdxW'(1);
        if (free_hit) begin
          case (cmd_q)
            CMD_ALLOC: free_d = fidx_q;
            CMD_MAP: begin
              mem_we           = 1'b1;
              mem_waddr        = fidx_q;
              mem_wdata        = '{base: lo_q, limit: hi_q + AddrW'(1), prot: prot_q};
              valid_d[fidx_q]  = 1'b1;
              res_ra_d         = lo_q;
              res_rs_d         = fidx_q;
            end
            default: begin
              // Split pieces keep the old permissions; lower piece first.
              mem_we          = 1'b1;
              mem_waddr       = fidx_q;
              valid_d[fidx_q] = 1'b1;
              if (pl_q) begin
                pl_d      = 1'b0;
                mem_wdata = '{base: ent_q.base, limit: lo_q, prot: ent_q.prot};
              end else begin
                pu_d      = 1'b0;
                mem_wdata = '{base: hi_q + AddrW'(1), limit: ent_q.limit, prot: ent_q.prot};
              end
            end
          endcase
        end else if (free_last) begin
          if (is_split) begin
            pl_d = 1'b0;
            pu_d = 1'b0;
          end else begin
            res_st_d = ST_FULL;
          end
        end
      end
      S_ALIGN: begin
        // Clear low set bits until one remains, then raise to a page.
        if (align_odd) begin
          align_d = align_q & (align_q - AddrW'(1));
        end else if (align_q < PageSize) begin
          align_d = PageSize;
        end
      end
      S_TADD: begin
        if (t_wrap) res_st_d = ST_WRAP;
        else lo_d = t_w & ~(align_q - AddrW'(1));
      end
      S_CAND: begin
        hit_d = 1'b0;
        if (cl_bad) res_st_d = ST_WRAP;
        else hi_d = cl_w;
      end
      S_DECIDE: begin
        case (cmd_q)
          CMD_MAP: begin
            if (hit_q) res_st_d = ST_OVERLAP;
          end
          CMD_ALLOC: begin
            if (hit_q) begin
              if (iter_q == IterW'(MAX_REGIONS)) begin
                res_st_d = ST_WRAP;
              end else begin
                cur_d  = best_end_q;
                iter_d = iter_q + IterW'(1);
              end
            end else begin
              mem_we          = 1'b1;
              mem_waddr       = free_q;
              mem_wdata       = '{base: lo_q, limit: hi_q + AddrW'(1), prot: prot_q};
              valid_d[free_q] = 1'b1;
              cursor_d        = hi_q + AddrW'(1);
              res_st_d        = ST_OK;
              res_ra_d        = lo_q;
              res_rs_d        = free_q;
            end
          end
          CMD_UNMAP, CMD_PROTECT: begin
            if (!phase_q) begin
              if (full_w) res_st_d = ST_FULL;
              else phase_d = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_FIN: begin
        if (out_take) begin
          out_d.status         = res_st_q;
          out_d.result_address = res_ra_q;
          out_d.region_offset  = found_q ? (addr_q - res_ra_q) : '0;
          out_d.region_slot    = SlotW'(res_rs_q);
          out_valid_d          = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      cursor_q    <= '0;
      idx_q       <= '0;
      fidx_q      <= '0;
      iter_q      <= '0;
      phase_q     <= 1'b0;
      hit_q       <= 1'b0;
      pl_q        <= 1'b0;
      pu_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      cursor_q    <= cursor_d;
      idx_q       <= idx_d;
      fidx_q      <= fidx_d;
      iter_q      <= iter_d;
      phase_q     <= phase_d;
      hit_q       <= hit_d;
      pl_q        <= pl_d;
      pu_q        <= pu_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    addr_q      <= addr_d;
    len_q       <= len_d;
    align_q     <= align_d;
    prot_q      <= prot_d;
    ap_q        <= ap_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    szoff_q     <= szoff_d;
    cur_q       <= cur_d;
    best_base_q <= best_base_d;
    best_end_q  <= best_end_d;
    free_q      <= free_d;
    cnt_q       <= cnt_d;
    need_q      <= need_d;
    nhit_q      <= nhit_d;
    b_q         <= b_d;
    af_q        <= af_d;
    ent_q       <= ent_d;
    res_st_q    <= res_st_d;
    res_ra_q    <= res_ra_d;
    res_rs_q    <= res_rs_d;
    found_q     <= found_d;
    out_q       <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `GRMU_ASSERT(a_accept_starts_prep, (in_valid_i && in_ready_o) |=> (state_q == S_PREP))
  `GRMU_ASSERT_NEVER(a_no_store_write_idle, mem_we && (state_q == S_IDLE))
  `GRMU_ASSERT(a_iter_bounded, iter_q <= IterW'(MAX_REGIONS))
  `GRMU_ASSERT(a_result_from_fin, $rose(out_valid_q) |-> ($past(state_q) == S_FIN))

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Guest region map unit: self-checking testbench
// A queue-fed driver sends command words. A clocked monitor compares each
// result word with the oldest prediction from a behavioural region table kept
// here. Phases vary the allocation start and the idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import grmu_pkg::*;

  localparam int unsigned NSlots     = MaxRegionsDef;
  localparam logic [63:0] PageMask   = 64'hFFF;
  localparam logic [63:0] PageSize   = 64'h1000;
  localparam int unsigned CycleLimit = 5000000;
  localparam int unsigned RandPerPh  = 175;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [63:0] cfg_data = '0;

  // Behavioural copy of the region table.
  logic [63:0] tbl_base [NSlots];
  logic [63:0] tbl_end [NSlots];
  logic [2:0] tbl_prot [NSlots];
  logic tbl_used [NSlots];
  logic [63:0] cursor;

  in_t cmd_q[$];
  out_t result_q[$];
  int unsigned src_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned err_cnt = 0;
  int unsigned words_in = 0;
  int unsigned words_out = 0;
  int unsigned cycles = 0;
  int unsigned status_seen [8];

  guest_region_map_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  function automatic int lowest_free_slot();
    for (int i = 0; i < NSlots; i++) begin
      if (!tbl_used[i]) return i;
    end
    return -1;
  endfunction

  function automatic bit touches(int i, logic [63:0] lo, logic [63:0] hi);
    return tbl_used[i] && tbl_base[i] <= hi && tbl_end[i] > lo;
  endfunction

  function automatic void store_region(int i, logic [63:0] b, logic [63:0] e,
                                       logic [2:0] p);
    tbl_base[i] = b;
    tbl_end[i] = e;
    tbl_prot[i] = p;
    tbl_used[i] = 1'b1;
  endfunction

  // Applies one command word to the table and returns the result it gives.
  function automatic out_t region_table_step(in_t w);
    out_t r;
    logic [63:0] base, span, last, a, cur, t, cand, cl, rb, re;
    logic [2:0] op;
    int j, hit, delta, need, used;
    bit ov, done, lo_part, hi_part;
    r = '0;
    base = w.address & ~PageMask;
    span = (w.length - 64'd1) | PageMask;
    last = base + span;
    case (w.cmd)
      CMD_CHECK: begin
        r.status = ST_UNMAPPED;
        for (int i = 0; i < NSlots; i++) begin
          if (tbl_used[i] && tbl_base[i] <= w.address && w.address < tbl_end[i]) begin
            r.status = ((tbl_prot[i] & w.access_prot) == w.access_prot) ? ST_OK : ST_PERM;
            r.result_address = tbl_base[i];
            r.region_offset = w.address - tbl_base[i];
            r.region_slot = SlotW'(i);
            break;
          end
        end
      end
      CMD_MAP: begin
        if (w.length == '0) begin
          r.status = ST_ZERO;
        end else if (last < base || last == '1) begin
          r.status = ST_WRAP;
        end else begin
          ov = 1'b0;
          for (int i = 0; i < NSlots; i++) if (touches(i, base, last)) ov = 1'b1;
          j = lowest_free_slot();
          if (ov) begin
            r.status = ST_OVERLAP;
          end else if (j < 0) begin
            r.status = ST_FULL;
          end else begin
            store_region(j, base, last + 64'd1, w.prot);
            r.status = ST_OK;
            r.result_address = base;
            r.region_slot = SlotW'(j);
          end
        end
      end
      CMD_ALLOC: begin
        j = lowest_free_slot();
        if (w.length == '0) begin
          r.status = ST_ZERO;
        end else if (j < 0) begin
          r.status = ST_FULL;
        end else begin
          a = w.alignment;
          if ((a & (a - 64'd1)) != '0) begin
            for (int k = 63; k >= 0; k--) begin
              if (a[k]) begin
                a = 64'd1 << k;
                break;
              end
            end
          end
          if (a < PageSize) a = PageSize;
          cur = cursor;
          done = 1'b0;
          r.status = ST_WRAP;
          for (int it = 0; it <= NSlots && !done; it++) begin
            t = cur + (a - 64'd1);
            if (t < cur) break;
            cand = t & ~(a - 64'd1);
            cl = cand + span;
            if (cl < cand || cl == '1) break;
            hit = -1;
            for (int i = 0; i < NSlots; i++) begin
              if (touches(i, cand, cl) && (hit < 0 || tbl_base[i] < tbl_base[hit])) hit = i;
            end
            if (hit < 0) begin
              store_region(j, cand, cl + 64'd1, w.prot);
              cursor = cl + 64'd1;
              r.status = ST_OK;
              r.result_address = cand;
              r.region_slot = SlotW'(j);
              done = 1'b1;
            end else begin
              cur = tbl_end[hit];
            end
          end
        end
      end
      CMD_UNMAP, CMD_PROTECT: begin
        if (w.length == '0) begin
          r.status = ST_OK;
        end else if (last < base) begin
          r.status = ST_WRAP;
        end else begin
          delta = 0;
          need = 0;
          used = 0;
          for (int i = 0; i < NSlots; i++) begin
            if (tbl_used[i]) used++;
            if (touches(i, base, last)) begin
              lo_part = base > tbl_base[i];
              hi_part = last < tbl_end[i] - 64'd1;
              delta += int'(lo_part) + int'(hi_part) - 1;
              need += int'(lo_part) + int'(hi_part);
            end
          end
          if (w.cmd == CMD_UNMAP ? (used + delta > NSlots) : (need > NSlots - used)) begin
            r.status = ST_FULL;
          end else begin
            r.status = ST_OK;
            for (int i = 0; i < NSlots; i++) begin
              if (!touches(i, base, last)) continue;
              rb = tbl_base[i];
              re = tbl_end[i];
              op = tbl_prot[i];
              lo_part = base > rb;
              hi_part = last < re - 64'd1;
              if (w.cmd == CMD_UNMAP) begin
                if (!lo_part && !hi_part) begin
                  tbl_used[i] = 1'b0;
                end else if (lo_part) begin
                  tbl_end[i] = base;
                  if (hi_part) begin
                    j = lowest_free_slot();
                    if (j >= 0) store_region(j, last + 64'd1, re, op);
                  end
                end else begin
                  tbl_base[i] = last + 64'd1;
                end
              end else begin
                if (lo_part) begin
                  j = lowest_free_slot();
                  if (j >= 0) store_region(j, rb, base, op);
                end
                if (hi_part) begin
                  j = lowest_free_slot();
                  if (j >= 0) store_region(j, last + 64'd1, re, op);
                end
                store_region(i, lo_part ? base : rb, hi_part ? last + 64'd1 : re, w.prot);
              end
            end
          end
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // Driver: a word leaves the queue only when the channel is free.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        result_q = {result_q, region_table_step(in_data)};
        words_in++;
      end
      if (cmd_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        in_data <= cmd_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: result words are compared against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_w;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        words_out++;
        if (result_q.size() == 0) begin
          $error("result word with no command outstanding: %h", out_data);
          err_cnt++;
        end else begin
          exp_w = result_q.pop_front();
          status_seen[exp_w.status]++;
          if (out_data.status !== exp_w.status) begin
            $error("status: expected %0d, got %0d", exp_w.status, out_data.status);
            err_cnt++;
          end
          if (out_data.result_address !== exp_w.result_address) begin
            $error("result_address: expected %h, got %h",
                   exp_w.result_address, out_data.result_address);
            err_cnt++;
          end
          if (out_data.region_offset !== exp_w.region_offset) begin
            $error("region_offset: expected %h, got %h",
                   exp_w.region_offset, out_data.region_offset);
            err_cnt++;
          end
          if (out_data.region_slot !== exp_w.region_slot) begin
            $error("region_slot: expected %0d, got %0d",
                   exp_w.region_slot, out_data.region_slot);
            err_cnt++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic push_word(logic [2:0] c, logic [63:0] ad, logic [63:0] len,
                           logic [63:0] al, logic [2:0] p, logic [2:0] ap);
    in_t w;
    w.cmd = c;
    w.address = ad;
    w.length = len;
    w.alignment = al;
    w.prot = p;
    w.access_prot = ap;
    cmd_q = {cmd_q, w};
  endtask

  function automatic in_t random_word(logic [63:0] win);
    in_t w;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) w.cmd = CMD_CHECK;
    else if (r < 45) w.cmd = CMD_MAP;
    else if (r < 60) w.cmd = CMD_ALLOC;
    else if (r < 78) w.cmd = CMD_UNMAP;
    else if (r < 97) w.cmd = CMD_PROTECT;
    else w.cmd = 3'($urandom_range(7, 5));
    case ($urandom_range(9))
      7: w.address = {$urandom, $urandom};
      8: w.address = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(1 << 20));
      9: w.address = win - 64'($urandom_range(1 << 16));
      default: w.address = win + {$urandom_range(63), 12'h0} + 64'($urandom_range(4095));
    endcase
    case ($urandom_range(9))
      0: w.length = '0;
      1: w.length = {$urandom, $urandom};
      2: w.length = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(1 << 13));
      7, 8: w.length = 64'($urandom_range(1, 4096));
      9: w.length = 64'h4_0000;
      default: w.length = 64'($urandom_range(1, 4 * 4096));
    endcase
    case ($urandom_range(9))
      0, 1: w.alignment = '0;
      7: w.alignment = {$urandom, $urandom};
      8: w.alignment = 64'd1 << 63;
      9: w.alignment = 64'($urandom_range(1, 1 << 18));
      default: w.alignment = 64'd1 << $urandom_range(0, 20);
    endcase
    w.prot = 3'($urandom);
    w.access_prot = 3'($urandom);
    // Now and then clear the whole window so that the table drains.
    if ($urandom_range(99) < 3) begin
      w.cmd = CMD_UNMAP;
      w.address = win;
      w.length = 64'h4_0000;
    end
    return w;
  endfunction

  task automatic write_alloc_start(logic [63:0] v);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cursor = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (cmd_q.size() > 0 || in_valid || result_q.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  initial begin
    logic [63:0] win;
    logic [63:0] starts [4];
    for (int i = 0; i < NSlots; i++) tbl_used[i] = 1'b0;
    cursor = '0;
    starts[0] = 64'h0;
    starts[1] = 64'hFFFF_FFFF_FFFF_F000;
    starts[2] = {$urandom, $urandom};
    starts[3] = 64'h8000_0000_0000_0000;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 21; rcv_idle_pct = 80; end
        1: begin src_idle_pct = 80; rcv_idle_pct = 21; end
        default: begin src_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      if (ph == 0) begin
        // Directed words, starting from the reset cursor.
        push_word(CMD_CHECK, 64'h1234, 0, 0, 0, 3'd1);
        push_word(CMD_MAP, 64'h0, 0, 0, 3'd3, 0);
        push_word(CMD_MAP, 64'hFFFF_FFFF_FFFF_F000, 64'h1000, 0, 3'd7, 0);
        push_word(CMD_MAP, 64'h5000, 64'hFFFF_FFFF_FFFF_FFFF, 0, 3'd7, 0);
        push_word(CMD_MAP, 64'h0FFF, 64'h3001, 0, 3'd3, 0);
        push_word(CMD_MAP, 64'h2000, 64'h1000, 0, 3'd7, 0);
        push_word(CMD_CHECK, 64'h2ABC, 0, 0, 0, 3'd3);
        push_word(CMD_CHECK, 64'h2ABC, 0, 0, 0, 3'd4);
        push_word(CMD_CHECK, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 3'd0);
        push_word(CMD_ALLOC, 0, 0, 64'h1000, 3'd1, 0);
        push_word(CMD_ALLOC, 0, 64'h1800, 64'h3000, 3'd1, 0);
        push_word(CMD_ALLOC, 0, 64'h1, 64'h0, 3'd2, 0);
        push_word(CMD_ALLOC, 0, 64'h1000, 64'h10, 3'd5, 0);
        push_word(CMD_ALLOC, 0, 64'h1000, 64'h8000_0000_0000_0000, 3'd6, 0);
        push_word(CMD_MAP, 64'h20000, 64'h8000, 0, 3'd7, 0);
        push_word(CMD_PROTECT, 64'h22000, 64'h2000, 0, 3'd1, 0);
        push_word(CMD_UNMAP, 64'h26000, 64'h1000, 0, 0, 0);
        push_word(CMD_UNMAP, 64'h20000, 0, 0, 0, 0);
        push_word(CMD_UNMAP, 64'hFFFF_FFFF_FFFF_F000, 64'h2000, 0, 0, 0);
        push_word(CMD_PROTECT, 64'hFFFF_FFFF_FFFF_E000, 64'h3000, 0, 3'd1, 0);
        push_word(3'd5, 64'h1000, 64'h1000, 0, 3'd7, 3'd7);
        push_word(3'd6, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 0, 0, 0);
        push_word(3'd7, 0, 0, 0, 0, 0);
        push_word(CMD_CHECK, 64'h23000, 0, 0, 0, 3'd1);
        push_word(CMD_UNMAP, 64'h0, 64'h10_0000, 0, 0, 0);
        drain();
      end
      write_alloc_start(starts[ph]);
      win = (starts[ph][63:62] == 2'b11) ? 64'h0000_7FFF_0000_0000 : starts[ph] & ~PageMask;
      for (int n = 0; n < RandPerPh; n++) cmd_q = {cmd_q, random_word(win)};
      drain();
    end

    $display("%0d command words sent, %0d results checked, over four cursor settings",
             words_in, words_out);
    $display("results by status 0..6: %0d %0d %0d %0d %0d %0d %0d", status_seen[0],
             status_seen[1], status_seen[2], status_seen[3], status_seen[4],
             status_seen[5], status_seen[6]);
    if (err_cnt == 0 && result_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
